/* hdl/pidf_pkg.sv */
// ----------------------------------------------------------------------------
// pidf_pkg - shared types and constants of the panel input debounce filter
// Holds field widths, event kinds, the button label table and the queue entry.
// ----------------------------------------------------------------------------
`default_nettype none
package pidf_pkg;
  localparam int unsigned ButtonCount = 20;
  localparam int unsigned RotaryCount = 2;
  localparam int unsigned SwitchCount = 2;
  localparam int unsigned PotCount    = 2;
  localparam int unsigned EventSlots  = ButtonCount + RotaryCount + SwitchCount + 1 + PotCount;
  localparam int unsigned SlotW       = $clog2(EventSlots);
  localparam int unsigned QueueDepth  = 4;
  localparam logic [19:0] AccMax      = 20'hFFFFF;

  localparam logic [2:0] KindButton = 3'd0;
  localparam logic [2:0] KindRotary = 3'd1;
  localparam logic [2:0] KindSwitch = 3'd2;
  localparam logic [2:0] KindStart  = 3'd3;
  localparam logic [2:0] KindPot    = 3'd4;

  localparam logic [2:0] RegButtonWin = 3'd0;
  localparam logic [2:0] RegRotaryHold = 3'd1;
  localparam logic [2:0] RegSwitchWin = 3'd2;
  localparam logic [2:0] RegStartWin  = 3'd3;
  localparam logic [2:0] RegPotEvery  = 3'd4;
  localparam logic [2:0] RegEmaShift  = 3'd5;
  localparam logic [2:0] RegDeadband  = 3'd6;

  function automatic logic [4:0] label_of_raw(input logic [3:0] r);
    logic [4:0] l;
    case (r)
      4'd0: l = 5'd1;   4'd1: l = 5'd2;   4'd2: l = 5'd3;   4'd3: l = 5'd4;
      4'd4: l = 5'd6;   4'd5: l = 5'd5;   4'd6: l = 5'd7;   4'd7: l = 5'd8;
      4'd8: l = 5'd9;   4'd9: l = 5'd10;  4'd10: l = 5'd11; 4'd11: l = 5'd12;
      4'd12: l = 5'd16; 4'd13: l = 5'd15; 4'd14: l = 5'd13; default: l = 5'd14;
    endcase
    return l;
  endfunction

  // one classified tick: which slots fire, their values, the new mask
  typedef struct packed {
    logic [EventSlots-1:0] fire;
    logic [2:0]            rot_a;
    logic [2:0]            rot_b;
    logic [1:0]            sw;
    logic                  start;
    logic [11:0]           pot_a;
    logic [11:0]           pot_b;
    logic [19:0]           mask;
  } tick_t;
endpackage
`default_nettype wire

/* hdl/pidf_front.sv */
// ----------------------------------------------------------------------------
// pidf_front - tick classifier
// Decodes one scan tick, updates debounce, rotary and EMA state and produces
// the set of events that the tick raises.
// ----------------------------------------------------------------------------
`default_nettype none
module pidf_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire logic [2:0]          enc_lo_i,
  input  wire logic [2:0]          enc_hi_i,
  input  wire logic [1:0]          patch_i,
  input  wire logic [3:0]          direct_i,
  input  wire logic [2:0]          rot_a_i,
  input  wire logic [2:0]          rot_b_i,
  input  wire logic [1:0]          sw_i,
  input  wire logic                start_i,
  input  wire logic [31:0]         now_i,
  input  wire logic [11:0]         pot_a_i,
  input  wire logic [11:0]         pot_b_i,
  input  wire logic [7:0]          btn_win_i,
  input  wire logic [9:0]          rot_hold_i,
  input  wire logic [7:0]          sw_win_i,
  input  wire logic [7:0]          start_win_i,
  input  wire logic [4:0]          pot_every_i,
  input  wire logic [3:0]          ema_shift_i,
  input  wire logic [11:0]         deadband_i,
  output pidf_pkg::tick_t          tick_o,
  output logic                     emit_o
);
  logic [19:0]       pressed_q, pressed_d;
  logic [31:0]       bstamp_q [20];
  logic [31:0]       bstamp_d [20];
  logic [2:0]        rpos_q [2], rpos_d [2], rcand_q [2], rcand_d [2];
  logic [31:0]       rstamp_q [2], rstamp_d [2];
  logic [1:0]        sws_q, sws_d;
  logic [31:0]       swstamp_q [2], swstamp_d [2];
  logic              st_q, st_d;
  logic [31:0]       ststamp_q, ststamp_d;
  logic [19:0]       acc_q [2], acc_d [2];
  logic [11:0]       rep_q [2], rep_d [2];
  logic [4:0]        div_q, div_d;
  logic              primed_q;
  logic [19:0]       now_b;
  logic [15:0]       raw;
  logic [2:0]        rot [2];
  logic [1:0]        swl;
  logic              stl;
  logic [11:0]       pot [2];
  logic [3:0]        sh;
  logic [4:0]        lbl;
  logic [31:0]       el;
  logic [20:0]       acc_w;
  logic [11:0]       v, dlt;
  logic [4:0]        div_inc;
  pidf_pkg::tick_t   t;

  always_comb begin
    raw = 16'd0;
    raw[0] = ~patch_i[0];
    raw[8] = ~patch_i[1];
    if (enc_lo_i != 3'd7) raw[3'd7 - enc_lo_i] = 1'b1;
    if (enc_hi_i != 3'd7) raw[{1'b1, 3'd7 - enc_hi_i}] = 1'b1;
    now_b = {~direct_i, 16'd0};
    for (int i = 0; i < 16; i++) begin
      lbl = pidf_pkg::label_of_raw(4'(i));
      if (raw[i]) now_b[lbl - 5'd1] = 1'b1;
    end
  end

  assign rot[0] = rot_a_i;
  assign rot[1] = rot_b_i;
  assign swl    = ~sw_i;
  assign stl    = ~start_i;
  assign pot[0] = pot_a_i;
  assign pot[1] = pot_b_i;
  assign sh     = (ema_shift_i > 4'd8) ? 4'd8 : ema_shift_i;

  always_comb begin
    pressed_d = pressed_q; bstamp_d = bstamp_q;
    rpos_d = rpos_q; rcand_d = rcand_q; rstamp_d = rstamp_q;
    sws_d = sws_q; swstamp_d = swstamp_q; st_d = st_q; ststamp_d = ststamp_q;
    acc_d = acc_q; rep_d = rep_q; div_d = div_q;
    t = '0;
    el = '0; acc_w = '0; v = '0; dlt = '0; div_inc = '0;
    if (!primed_q) begin
      pressed_d = now_b;
      for (int i = 0; i < 20; i++) bstamp_d[i] = now_i;
      for (int i = 0; i < 2; i++) begin
        rpos_d[i] = rot[i]; rcand_d[i] = rot[i]; rstamp_d[i] = now_i;
        swstamp_d[i] = now_i;
        acc_d[i] = 20'({8'd0, pot[i]} << sh);
        rep_d[i] = pot[i];
      end
      sws_d = swl; st_d = stl; ststamp_d = now_i;
    end else begin
      for (int i = 0; i < 20; i++) begin
        el = now_i - bstamp_q[i];
        if (now_b[i] != pressed_q[i] && el >= {24'd0, btn_win_i}) begin
          pressed_d[i] = now_b[i];
          bstamp_d[i] = now_i;
          t.fire[i] = now_b[i];
        end
      end
      for (int i = 0; i < 2; i++) begin
        el = now_i - rstamp_q[i];
        if (rot[i] == rpos_q[i]) begin
          rcand_d[i] = rot[i];
        end else if (rot[i] == rcand_q[i]) begin
          if (el >= {22'd0, rot_hold_i}) begin
            rpos_d[i] = rot[i];
            t.fire[20 + i] = 1'b1;
          end
        end else begin
          rcand_d[i] = rot[i];
          rstamp_d[i] = now_i;
        end
      end
      for (int i = 0; i < 2; i++) begin
        el = now_i - swstamp_q[i];
        if (swl[i] != sws_q[i] && el >= {24'd0, sw_win_i}) begin
          sws_d[i] = swl[i];
          swstamp_d[i] = now_i;
          t.fire[22 + i] = 1'b1;
        end
      end
      el = now_i - ststamp_q;
      if (stl != st_q && el >= {24'd0, start_win_i}) begin
        st_d = stl;
        ststamp_d = now_i;
        t.fire[24] = 1'b1;
      end
      div_inc = div_q + 5'd1;
      div_d = div_inc;
      if (div_inc >= pot_every_i) begin
        div_d = 5'd0;
        for (int i = 0; i < 2; i++) begin
          acc_w = {1'b0, acc_q[i]} - {1'b0, acc_q[i] >> sh} + {9'd0, pot[i]};
          if (acc_w > {1'b0, pidf_pkg::AccMax}) acc_w = {1'b0, pidf_pkg::AccMax};
          acc_d[i] = acc_w[19:0];
          v = 12'(acc_w[19:0] >> sh);
          dlt = (v >= rep_q[i]) ? v - rep_q[i] : rep_q[i] - v;
          if (dlt >= deadband_i) begin
            rep_d[i] = v;
            t.fire[25 + i] = 1'b1;
          end
          if (i == 0) t.pot_a = v; else t.pot_b = v;
        end
      end
    end
    t.rot_a = rot[0];
    t.rot_b = rot[1];
    t.sw    = swl;
    t.start = stl;
    t.mask  = pressed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0; rpos_q <= '{default: '0}; rcand_q <= '{default: '0};
      rstamp_q <= '{default: '0}; sws_q <= '0; swstamp_q <= '{default: '0};
      st_q <= 1'b0; ststamp_q <= '0; acc_q <= '{default: '0};
      rep_q <= '{default: '0}; div_q <= '0; primed_q <= 1'b0;
      bstamp_q <= '{default: '0};
    end else if (take_i) begin
      pressed_q <= pressed_d; bstamp_q <= bstamp_d; rpos_q <= rpos_d;
      rcand_q <= rcand_d; rstamp_q <= rstamp_d; sws_q <= sws_d;
      swstamp_q <= swstamp_d; st_q <= st_d; ststamp_q <= ststamp_d;
      acc_q <= acc_d; rep_q <= rep_d; div_q <= div_d; primed_q <= 1'b1;
    end
  end

  assign tick_o = t;
  assign emit_o = take_i && (t.fire != '0);
endmodule
`default_nettype wire

/* hdl/pidf_queue.sv */
// ----------------------------------------------------------------------------
// pidf_queue - tick queue
// Short FIFO of classified ticks between classifier and event sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module pidf_queue #(
  parameter int unsigned Depth = pidf_pkg::QueueDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire pidf_pkg::tick_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output pidf_pkg::tick_t data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  pidf_pkg::tick_t mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]     cnt_q, cnt_d;

  always_comb begin
    wr_d = wr_q; rd_d = rd_q; cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
endmodule
`default_nettype wire

/* hdl/pidf_back.sv */
// ----------------------------------------------------------------------------
// pidf_back - event sequencer
// Walks a tick's fired slots into an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module pidf_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire pidf_pkg::tick_t tick_i,
  output logic            pop_o,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [39:0]     m_axis_tdata,
  output logic [2:0]      m_axis_tuser,
  output logic            m_axis_tlast
);
  logic [pidf_pkg::EventSlots-1:0] done_q, done_d, left;
  logic [pidf_pkg::SlotW-1:0]      sel;
  logic                            found, more, load;
  logic                            vld_q;
  logic [39:0]                     dat_q, dat_d;
  logic [2:0]                      usr_q;
  logic                            lst_q;
  logic [2:0]                      kind;
  logic [4:0]                      id;
  logic [11:0]                     val;

  assign left = tick_i.fire & ~done_q;

  always_comb begin
    sel = '0; found = 1'b0;
    for (int i = pidf_pkg::EventSlots - 1; i >= 0; i--) begin
      if (left[i]) begin
        sel = pidf_pkg::SlotW'(i); found = 1'b1;
      end
    end
    more = (left & ~(pidf_pkg::EventSlots'(1) << sel)) != '0;
  end

  always_comb begin
    kind = pidf_pkg::KindButton; id = 5'(sel) + 5'd1; val = '0;
    if (sel >= 5'd25) begin
      kind = pidf_pkg::KindPot; id = 5'(sel) - 5'd24;
      val = (sel == 5'd25) ? tick_i.pot_a : tick_i.pot_b;
    end else if (sel == 5'd24) begin
      kind = pidf_pkg::KindStart; id = 5'd1; val = {11'd0, tick_i.start};
    end else if (sel >= 5'd22) begin
      kind = pidf_pkg::KindSwitch; id = 5'(sel) - 5'd21;
      val = {11'd0, tick_i.sw[sel[0]]};
    end else if (sel >= 5'd20) begin
      kind = pidf_pkg::KindRotary; id = 5'(sel) - 5'd19;
      val = {9'd0, sel[0] ? tick_i.rot_b : tick_i.rot_a};
    end
  end

  assign load  = !empty_i && found && (!vld_q || m_axis_tready);
  assign pop_o = load && !more;
  assign dat_d = {3'd0, tick_i.mask, val, id};

  always_comb begin
    done_d = done_q;
    if (load) done_d = more ? (done_q | (pidf_pkg::EventSlots'(1) << sel)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; done_q <= '0;
    end else begin
      done_q <= done_d;
      if (load) vld_q <= 1'b1;
      else if (m_axis_tready) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dat_q <= dat_d; usr_q <= kind; lst_q <= !more;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = dat_q;
  assign m_axis_tuser  = usr_q;
  assign m_axis_tlast  = lst_q;
endmodule
`default_nettype wire

/* hdl/panel_input_debounce_filter.sv */
// ----------------------------------------------------------------------------
// panel_input_debounce_filter - panel scan debouncer and pot filter
// Classifies scan ticks into events and sends them out one request at a time.
// ----------------------------------------------------------------------------
//  channel   dir  tdata / tuser / tlast
//  s_axis    in   scan tick, 80-bit tdata
//  m_axis    out  event, 40-bit tdata, 3-bit tuser kind, tlast on final event
//  cfg       in   write enable, 3-bit index, 12-bit data
// A tick is classified in the cycle it is taken; a tick's events then
// leave at one per cycle from the sequencer while m_axis_tready is high.
// A four-entry tick queue decouples both sides; input stalls only when it is
// full. Reset clears filter and sequencing state, and loads config defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module panel_input_debounce_filter #(
  parameter int unsigned QueueDepth = pidf_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // enc_code_low, enc_code_high, patch_levels, direct_levels, rotary_a,
  // rotary_b, switch_levels, start_level, now_ms, pot_a, pot_b
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // event_id, event_value, held_mask
  output logic [39:0]      m_axis_tdata,
  // event_kind
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);
  logic [7:0]  btn_win_q, sw_win_q, st_win_q;
  logic [9:0]  rot_hold_q;
  logic [4:0]  pot_every_q;
  logic [3:0]  ema_q;
  logic [11:0] db_q;
  logic        take, emit, full, empty, pop;
  pidf_pkg::tick_t tick_f, tick_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_win_q <= 8'd5; rot_hold_q <= 10'd100; sw_win_q <= 8'd10;
      st_win_q <= 8'd5; pot_every_q <= 5'd16; ema_q <= 4'd5; db_q <= 12'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pidf_pkg::RegButtonWin:  btn_win_q   <= cfg_data_i[7:0];
        pidf_pkg::RegRotaryHold: rot_hold_q  <= cfg_data_i[9:0];
        pidf_pkg::RegSwitchWin:  sw_win_q    <= cfg_data_i[7:0];
        pidf_pkg::RegStartWin:   st_win_q    <= cfg_data_i[7:0];
        pidf_pkg::RegPotEvery:   pot_every_q <= cfg_data_i[4:0];
        pidf_pkg::RegEmaShift:   ema_q       <= cfg_data_i[3:0];
        pidf_pkg::RegDeadband:   db_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign take = s_axis_tvalid && !full;

  pidf_front u_front (
    .clk_i, .rst_ni, .take_i(take),
    .enc_lo_i(s_axis_tdata[2:0]), .enc_hi_i(s_axis_tdata[5:3]),
    .patch_i(s_axis_tdata[7:6]), .direct_i(s_axis_tdata[11:8]),
    .rot_a_i(s_axis_tdata[14:12]), .rot_b_i(s_axis_tdata[17:15]),
    .sw_i(s_axis_tdata[19:18]), .start_i(s_axis_tdata[20]),
    .now_i(s_axis_tdata[52:21]), .pot_a_i(s_axis_tdata[64:53]),
    .pot_b_i(s_axis_tdata[76:65]),
    .btn_win_i(btn_win_q), .rot_hold_i(rot_hold_q), .sw_win_i(sw_win_q),
    .start_win_i(st_win_q), .pot_every_i(pot_every_q), .ema_shift_i(ema_q),
    .deadband_i(db_q), .tick_o(tick_f), .emit_o(emit)
  );

  pidf_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(emit), .data_i(tick_f), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(tick_b)
  );

  pidf_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .tick_i(tick_b), .pop_o(pop),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );
endmodule
`default_nettype wire
